// ===== rtl/core/lfr_pkg.sv =====
package lfr_pkg;

   // Fixed field widths
   localparam int unsigned CNT_W   = 3;
   localparam int unsigned ENTRY_W = 12;
   localparam int unsigned BCNT_W  = 4;

   // Framing bytes and diagnostic identifiers
   localparam logic [7:0]        BREAK_BYTE     = 8'h00;
   localparam logic [7:0]        SYNC_BYTE      = 8'h55;
   localparam logic [5:0]        DIAG_ID_MASTER = 6'h3C;
   localparam logic [5:0]        DIAG_ID_SLAVE  = 6'h3D;
   localparam logic [BCNT_W-1:0] BYTE_COUNT_MAX = 4'hF;

   // Register indexes on the CSR channel
   localparam int unsigned REG_FILTER_COUNT = 0;
   localparam int unsigned REG_FILTER_BASE  = 1;

   // Request modes
   typedef enum logic [1:0] {
      MODE_BYTE  = 2'd0,
      MODE_LINE  = 2'd1,
      MODE_REARM = 2'd2
   } mode_type;

   // Result status codes
   typedef enum logic [3:0] {
      ST_BUSY       = 4'd0,
      ST_BREAK_ERR  = 4'd1,
      ST_SYNC_ERR   = 4'd2,
      ST_PARITY_ERR = 4'd3,
      ST_NO_MATCH   = 4'd4,
      ST_HEADER_OK  = 4'd5,
      ST_FRAME_OK   = 4'd6,
      ST_CHECK_ERR  = 4'd7,
      ST_IGNORED    = 4'd8,
      ST_LINE_RESET = 4'd9,
      ST_ARMED      = 4'd10
   } status_type;

   // Shared unit operations
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_CMP = 1'b1
   } alu_op_type;

   // Filter table entry packing
   typedef struct packed {
      logic       enh_ok;
      logic       classic_ok;
      logic       hdr_only;
      logic [2:0] len_m1;
      logic [5:0] id;
   } filter_entry_type;

   // Protected identifier: id plus its two parity bits
   function automatic logic [7:0] protect_id(input logic [5:0] id);
      logic p0;
      logic p1;
      p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
      p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
      return {p1, p0, id};
   endfunction

endpackage

// ===== rtl/core/lfr_ifs.sv =====
// Request channel: one UART byte or line event per item
interface lfr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] rx_byte;

   modport source (output valid, mode, rx_byte, input ready);
   modport sink   (input valid, mode, rx_byte, output ready);
endinterface

// Response channel: one status item per result
interface lfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] status;
   logic [5:0] frame_id;
   logic       frame_class;
   logic [7:0] data_byte;
   logic [2:0] byte_index;
   logic       last;

   modport source (output valid, status, frame_id, frame_class, data_byte, byte_index, last,
                   input ready);
   modport sink   (input valid, status, frame_id, frame_class, data_byte, byte_index, last,
                   output ready);
endinterface

// Register write channel
interface lfr_csr_if #(parameter int IDX_W = 3);
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [11:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lfr_regs.sv =====
module lfr_regs #(
   parameter int FILTER_SLOTS = 4,
   parameter int IDX_W        = 3
) (
   input  logic                                         clock,
   input  logic                                         reset,
   lfr_csr_if.sink                                      csr_ch,
   output logic [lfr_pkg::CNT_W-1:0]                    filter_count,
   output lfr_pkg::filter_entry_type [FILTER_SLOTS-1:0] filter_entry
);
   import lfr_pkg::*;

   logic [CNT_W-1:0]                    count_ff, count_in;
   filter_entry_type [FILTER_SLOTS-1:0] entry_ff, entry_in;
   logic                                wr_fire;

   assign csr_ch.ready = !reset;
   assign wr_fire      = csr_ch.valid && csr_ch.ready;

   // Index decode; writes beyond the table are dropped
   always_comb begin
      count_in = count_ff;
      entry_in = entry_ff;
      if (wr_fire) begin
         if (csr_ch.index == IDX_W'(REG_FILTER_COUNT)) begin
            count_in = csr_ch.data[CNT_W-1:0];
         end
         for (int s = 0; s < FILTER_SLOTS; s++) begin
            if (csr_ch.index == IDX_W'(REG_FILTER_BASE + s)) begin
               entry_in[s] = filter_entry_type'(csr_ch.data);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(1);
         entry_ff <= '0;
      end else begin
         count_ff <= count_in;
         entry_ff <= entry_in;
      end
   end

   assign filter_count = count_ff;
   assign filter_entry = entry_ff;

endmodule

// ===== rtl/core/lfr_alu.sv =====
module lfr_alu (
   input  lfr_pkg::alu_op_type op,
   input  logic [7:0]          a,
   input  logic [7:0]          b,
   output logic [7:0]          result,
   output logic                equal
);
   import lfr_pkg::*;

   logic [8:0] sum;

   // Byte add with end-around carry, or bitwise difference for compares
   assign sum = {1'b0, a} + {1'b0, b};

   always_comb begin
      case (op)
         ALU_ADD: result = sum[7:0] + {7'd0, sum[8]};
         default: result = a ^ b;
      endcase
   end

   // Only meaningful for compares
   assign equal = ~|result;

endmodule

// ===== rtl/core/lin_frame_receiver_core.sv =====
// LIN slave frame receiver.
// req_ch carries one item per UART event: mode 0 a received byte, mode 1 a
// line-status break event, mode 2 re-arms reception after a completed frame.
// rsp_ch returns one status item per request, except a good frame, which
// returns one FRAME_OK item per payload byte with last set on the final one.
// csr_ch writes the filter count (index 0) and the filter entries (1 on);
// it is always ready outside reset and must only be used while idle.
// A plain byte passes through the emit state into the output register. A PID
// walks the filter table with the shared compare unit, one entry per cycle.
// The checksum byte walks the payload through the shared end-around adder
// once per checksum kind tried (at most two), then streams one result per
// cycle while rsp_ch is not stalled.
// req_ch.ready is high only while the sequencer is idle; a new item can be
// taken while the last result still waits in the output register.
// A stalled rsp_ch holds the current result and the sequencer waits.
// Synchronous reset clears the sequencer, disarms reception, returns to
// waiting for a break and loads the filter count with 1 and entries with 0.
module lin_frame_receiver_core #(
   parameter int FILTER_SLOTS = 4,
   parameter int MAX_PAYLOAD  = 8
) (
   input  logic       clock,
   input  logic       reset,
   lfr_req_if.sink    req_ch,
   lfr_rsp_if.source  rsp_ch,
   lfr_csr_if.sink    csr_ch
);
   import lfr_pkg::*;

   localparam int SLOT_W = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;
   localparam int SCNT_W = $clog2(FILTER_SLOTS + 1);
   localparam int PAY_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int IDX_W  = $clog2(FILTER_SLOTS + 1);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_EMIT   = 6'b000010,
      S_SEARCH = 6'b000100,
      S_SUM    = 6'b001000,
      S_CMP    = 6'b010000,
      S_STREAM = 6'b100000
   } seq_state_type;

   typedef enum logic [5:0] {
      PH_BREAK = 6'b000001,
      PH_SYNC  = 6'b000010,
      PH_PID   = 6'b000100,
      PH_DATA  = 6'b001000,
      PH_CHECK = 6'b010000,
      PH_DONE  = 6'b100000
   } phase_type;

   // Configuration
   logic [CNT_W-1:0]                    filter_count;
   filter_entry_type [FILTER_SLOTS-1:0] filter_entry;

   // Control state
   seq_state_type     state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic              armed_ff, armed_in;
   logic [BCNT_W-1:0] byte_count_ff, byte_count_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [SCNT_W-1:0] scan_ff, scan_in;
   logic [LEN_W-1:0]  step_ff, step_in;
   logic [7:0]        acc_ff, acc_in;
   logic [7:0]        rx_ff, rx_in;
   logic              enh_ff, enh_in;
   status_type        emit_status_ff, emit_status_in;
   logic [5:0]        emit_id_ff, emit_id_in;

   // Output register
   status_type        rsp_status_ff, rsp_status_in;
   logic [5:0]        rsp_id_ff, rsp_id_in;
   logic              rsp_class_ff, rsp_class_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic [2:0]        rsp_index_ff, rsp_index_in;
   logic              rsp_last_ff, rsp_last_in;

   // Payload store
   logic [7:0]        payload_mem [MAX_PAYLOAD];
   logic              pay_we;
   logic [7:0]        pay_rd_ff;

   // Derived values
   logic              req_fire;
   logic              out_free;
   logic              rsp_load;
   filter_entry_type  cur_entry;
   filter_entry_type  scan_entry;
   logic [3:0]        len_full;
   logic [LEN_W-1:0]  cur_len;
   logic [3:0]        n_active;
   logic [7:0]        seed;
   logic [BCNT_W-1:0] cnt_inc;
   logic              step_last;

   // Shared unit
   alu_op_type        alu_op;
   logic [7:0]        alu_a, alu_b, alu_result;
   logic              alu_eq;

   lfr_regs #(
      .FILTER_SLOTS (FILTER_SLOTS),
      .IDX_W        (IDX_W)
   ) u_regs (
      .clock        (clock),
      .reset        (reset),
      .csr_ch       (csr_ch),
      .filter_count (filter_count),
      .filter_entry (filter_entry)
   );

   lfr_alu u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_result),
      .equal  (alu_eq)
   );

   // Handshakes
   assign req_ch.ready = (state_ff == S_IDLE) && !reset;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // Entry views, length saturated to the payload store
   assign cur_entry  = filter_entry[slot_ff];
   assign scan_entry = filter_entry[scan_ff[SLOT_W-1:0]];
   assign len_full   = {1'b0, cur_entry.len_m1} + 4'd1;
   assign cur_len    = (len_full > 4'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : LEN_W'(len_full);
   assign n_active   = (4'(filter_count) > 4'(FILTER_SLOTS)) ? 4'(FILTER_SLOTS)
                                                              : 4'(filter_count);
   assign seed       = ((cur_entry.id == DIAG_ID_MASTER) || (cur_entry.id == DIAG_ID_SLAVE))
                       ? 8'h00 : protect_id(cur_entry.id);
   assign cnt_inc    = (byte_count_ff != BYTE_COUNT_MAX) ? byte_count_ff + 4'd1 : byte_count_ff;
   assign step_last  = (LEN_W'(step_ff + 1'b1) == cur_len);

   // Operand select for the shared unit
   always_comb begin
      alu_op = ALU_ADD;
      alu_a  = acc_ff;
      alu_b  = pay_rd_ff;
      if (state_ff == S_SEARCH) begin
         alu_op = ALU_CMP;
         alu_a  = {2'b00, scan_entry.id};
         alu_b  = {2'b00, rx_ff[5:0]};
      end else if (state_ff == S_CMP) begin
         alu_op = ALU_CMP;
         alu_a  = ~acc_ff;
         alu_b  = rx_ff;
      end
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      armed_in       = armed_ff;
      byte_count_in  = byte_count_ff;
      slot_in        = slot_ff;
      scan_in        = scan_ff;
      step_in        = step_ff;
      acc_in         = acc_ff;
      rx_in          = rx_ff;
      enh_in         = enh_ff;
      emit_status_in = emit_status_ff;
      emit_id_in     = emit_id_ff;
      pay_we         = 1'b0;
      rsp_load       = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_class_in   = rsp_class_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in       = S_EMIT;
               emit_status_in = ST_BUSY;
               emit_id_in     = '0;
               if (req_ch.mode == MODE_LINE) begin
                  phase_in       = PH_BREAK;
                  emit_status_in = ST_LINE_RESET;
               end else if (req_ch.mode == MODE_REARM) begin
                  if (armed_ff) begin
                     emit_status_in = ST_IGNORED;
                  end else begin
                     armed_in       = 1'b1;
                     phase_in       = PH_BREAK;
                     emit_status_in = ST_ARMED;
                  end
               end else if ((req_ch.mode != MODE_BYTE) || !armed_ff) begin
                  emit_status_in = ST_IGNORED;
               end else begin
                  unique case (phase_ff)
                     PH_BREAK: begin
                        if (req_ch.rx_byte != BREAK_BYTE) begin
                           emit_status_in = ST_BREAK_ERR;
                        end else begin
                           byte_count_in = '0;
                           phase_in      = PH_SYNC;
                        end
                     end
                     PH_SYNC: begin
                        if (req_ch.rx_byte != SYNC_BYTE) begin
                           phase_in       = PH_BREAK;
                           emit_status_in = ST_SYNC_ERR;
                        end else begin
                           phase_in = PH_PID;
                        end
                     end
                     PH_PID: begin
                        if (req_ch.rx_byte != protect_id(req_ch.rx_byte[5:0])) begin
                           phase_in       = PH_BREAK;
                           emit_status_in = ST_PARITY_ERR;
                        end else begin
                           rx_in    = req_ch.rx_byte;
                           scan_in  = '0;
                           state_in = S_SEARCH;
                        end
                     end
                     PH_DATA: begin
                        pay_we        = (byte_count_ff < BCNT_W'(MAX_PAYLOAD));
                        byte_count_in = cnt_inc;
                        if (cnt_inc >= BCNT_W'(cur_len)) begin
                           phase_in = PH_CHECK;
                        end
                     end
                     PH_CHECK: begin
                        rx_in   = req_ch.rx_byte;
                        step_in = '0;
                        if (cur_entry.classic_ok) begin
                           enh_in   = 1'b0;
                           acc_in   = 8'h00;
                           state_in = S_SUM;
                        end else if (cur_entry.enh_ok) begin
                           enh_in   = 1'b1;
                           acc_in   = seed;
                           state_in = S_SUM;
                        end else begin
                           phase_in       = PH_BREAK;
                           emit_status_in = ST_CHECK_ERR;
                           emit_id_in     = cur_entry.id;
                        end
                     end
                     default: begin
                        phase_in = PH_BREAK;
                     end
                  endcase
               end
            end
         end

         // One filter entry per cycle through the compare unit
         S_SEARCH: begin
            if (4'(scan_ff) >= n_active) begin
               phase_in       = PH_BREAK;
               emit_status_in = ST_NO_MATCH;
               emit_id_in     = '0;
               state_in       = S_EMIT;
            end else if (alu_eq) begin
               slot_in    = scan_ff[SLOT_W-1:0];
               state_in   = S_EMIT;
               emit_id_in = '0;
               if (scan_entry.hdr_only) begin
                  armed_in       = 1'b0;
                  phase_in       = PH_DONE;
                  emit_status_in = ST_HEADER_OK;
                  emit_id_in     = scan_entry.id;
               end else begin
                  phase_in       = PH_DATA;
                  emit_status_in = ST_BUSY;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         // One payload byte per cycle into the end-around sum
         S_SUM: begin
            acc_in  = alu_result;
            step_in = step_ff + 1'b1;
            if (step_last) begin
               state_in = S_CMP;
            end
         end

         // Inverted sum against the received checksum byte
         S_CMP: begin
            step_in = '0;
            if (alu_eq) begin
               armed_in = 1'b0;
               phase_in = PH_DONE;
               state_in = S_STREAM;
            end else if (!enh_ff && cur_entry.enh_ok) begin
               enh_in   = 1'b1;
               acc_in   = seed;
               state_in = S_SUM;
            end else begin
               phase_in       = PH_BREAK;
               emit_status_in = ST_CHECK_ERR;
               emit_id_in     = cur_entry.id;
               state_in       = S_EMIT;
            end
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = emit_status_ff;
               rsp_id_in     = emit_id_ff;
               rsp_class_in  = 1'b0;
               rsp_data_in   = 8'h00;
               rsp_index_in  = 3'd0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_STREAM: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = ST_FRAME_OK;
               rsp_id_in     = cur_entry.id;
               rsp_class_in  = enh_ff;
               rsp_data_in   = pay_rd_ff;
               rsp_index_in  = 3'(step_ff);
               rsp_last_in   = step_last;
               step_in       = step_ff + 1'b1;
               if (step_last) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output valid: loaded, or cleared once taken
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_BREAK;
         armed_ff      <= 1'b0;
         byte_count_ff <= '0;
         slot_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         armed_ff      <= armed_in;
         byte_count_ff <= byte_count_in;
         slot_ff       <= slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working and output payload registers
   always_ff @(posedge clock) begin
      scan_ff        <= scan_in;
      step_ff        <= step_in;
      acc_ff         <= acc_in;
      rx_ff          <= rx_in;
      enh_ff         <= enh_in;
      emit_status_ff <= emit_status_in;
      emit_id_ff     <= emit_id_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_class_ff   <= rsp_class_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Payload store: write on data bytes, read ahead at the next step
   always_ff @(posedge clock) begin
      if (pay_we) begin
         payload_mem[byte_count_ff[PAY_W-1:0]] <= req_ch.rx_byte;
      end
      pay_rd_ff <= payload_mem[step_in[PAY_W-1:0]];
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.frame_id    = rsp_id_ff;
   assign rsp_ch.frame_class = rsp_class_ff;
   assign rsp_ch.data_byte   = rsp_data_ff;
   assign rsp_ch.byte_index  = rsp_index_ff;
   assign rsp_ch.last        = rsp_last_ff;

endmodule

// ===== rtl/core/lfr_checker.sv =====
module lfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_status,
   input logic [5:0] rsp_frame_id,
   input logic       rsp_frame_class,
   input logic [7:0] rsp_data_byte,
   input logic [2:0] rsp_byte_index,
   input logic       rsp_last
);
   import lfr_pkg::*;

   // A waiting result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // Only frame data items carry payload fields; all others end their item
   a_plain_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_FRAME_OK) |->
         (rsp_data_byte == 8'h00) && (rsp_byte_index == 3'd0) &&
         !rsp_frame_class && rsp_last)
      else $error("non-frame result with payload fields");

   // Identifier only on header ok, frame ok and checksum error
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_HEADER_OK) && (rsp_status != ST_FRAME_OK) &&
      (rsp_status != ST_CHECK_ERR) |-> (rsp_frame_id == 6'd0))
      else $error("frame id on a status that has none");

   // Frame data streams without gaps, index counting up
   a_stream_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_status == ST_FRAME_OK) && !rsp_last |=>
         rsp_valid && (rsp_status == ST_FRAME_OK) &&
         (rsp_byte_index == 3'($past(rsp_byte_index) + 3'd1)))
      else $error("frame data stream broken");

   // A taken item drops ready while the receiver works on it
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken on consecutive cycles");

endmodule

bind lin_frame_receiver_core lfr_checker u_lfr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_frame_id    (rsp_ch.frame_id),
   .rsp_frame_class (rsp_ch.frame_class),
   .rsp_data_byte   (rsp_ch.data_byte),
   .rsp_byte_index  (rsp_ch.byte_index),
   .rsp_last        (rsp_ch.last)
);
